// ===== design/hld_pkg.sv =====
`timescale 1ns / 1ps

package hld_pkg;

    localparam int CFG_W       = 13;
    localparam int IDX_W       = 2;
    localparam int PIX_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } pixel_t;

    // what the back end has to do for one accepted input pixel
    typedef struct packed {
        logic blend;
        logic exact;
        logic row_end;
        logic frame_end;
    } cmd_flags_t;

    typedef struct packed {
        logic mul;
        logic load;
        logic step;
    } blend_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_LOAD,
        BK_DIV,
        BK_BLEND_OUT,
        BK_EXACT_OUT
    } back_state_t;

    // largest size a 13-bit register can reach after saturation
    function automatic int eff_max(input int limit);
        int cfg_max;
        cfg_max = (1 << CFG_W) - 1;
        return (limit < cfg_max) ? limit : cfg_max;
    endfunction

endpackage

// ===== design/hld_front.sv =====
`timescale 1ns / 1ps

module hld_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int WGT_W      = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hld_pkg::IDX_W-1:0]    cfg_index,
    input  logic [hld_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  hld_pkg::pixel_t              s_pix,
    input  logic                         q_full,
    output logic                         q_push,
    output hld_pkg::cmd_flags_t          q_flags,
    output hld_pkg::pixel_t              q_held,
    output hld_pkg::pixel_t              q_cur,
    output logic [WGT_W-1:0]             q_wf,
    output logic [WGT_W-1:0]             q_ws
);

    localparam int ES_MAX = hld_pkg::eff_max(MAX_WIDTH);
    localparam int EH_MAX = hld_pkg::eff_max(MAX_HEIGHT);
    localparam int EW     = WGT_W;
    localparam int CW     = $clog2(ES_MAX);
    localparam int HW     = $clog2(EH_MAX + 1);
    localparam int RW     = (EH_MAX > 1) ? $clog2(EH_MAX) : 1;

    logic [hld_pkg::CFG_W-1:0] src_width_reg, dst_width_reg, src_height_reg;

    logic [EW-1:0] acc_reg, acc_next;
    logic          pend_reg, pend_next;
    logic [EW-1:0] wf_reg, ws_reg;
    hld_pkg::pixel_t held_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [EW-1:0] es, ed, acc_base, right;
    logic [HW-1:0] eh;
    logic [EW:0]   sum;
    logic          last_col, last_row, upscale, reach, hold, accept;
    hld_pkg::cmd_flags_t flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= hld_pkg::SRC_WIDTH_RST;
            dst_width_reg  <= hld_pkg::DST_WIDTH_RST;
            src_height_reg <= hld_pkg::SRC_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hld_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                hld_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_wdata;
                hld_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero source sizes and oversized register values mapped to usable sizes
    always_comb begin
        if (src_width_reg == '0) begin
            es = EW'(1);
        end else if (int'(src_width_reg) > ES_MAX) begin
            es = EW'(ES_MAX);
        end else begin
            es = EW'(src_width_reg);
        end
        if (int'(dst_width_reg) > ES_MAX) begin
            ed = EW'(ES_MAX);
        end else begin
            ed = EW'(dst_width_reg);
        end
        if (src_height_reg == '0) begin
            eh = HW'(1);
        end else if (int'(src_height_reg) > EH_MAX) begin
            eh = HW'(EH_MAX);
        end else begin
            eh = HW'(src_height_reg);
        end
    end

    assign accept   = s_valid && s_ready;
    assign s_ready  = !q_full;
    assign last_col = (EW'(col_reg) + EW'(1)) >= es;
    assign last_row = (HW'(row_reg) + HW'(1)) >= eh;
    assign upscale  = ed > es;
    assign acc_base = (acc_reg >= es) ? '0 : acc_reg;
    assign sum      = {1'b0, acc_base} + {1'b0, ed};
    assign reach    = sum >= {1'b0, es};
    assign right    = EW'(sum - {1'b0, es});

    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        hold      = 1'b0;
        flags     = '0;
        if (upscale) begin
            pend_next = 1'b0;
            acc_next  = '0;
        end else begin
            flags.blend = pend_reg;
            pend_next   = 1'b0;
            acc_next    = acc_base;
            if (reach) begin
                if (right == '0 || last_col) begin
                    flags.exact     = 1'b1;
                    flags.row_end   = last_col;
                    flags.frame_end = last_col && last_row;
                    acc_next        = '0;
                end else begin
                    hold      = 1'b1;
                    pend_next = 1'b1;
                    acc_next  = right;
                end
            end else begin
                acc_next = EW'(sum);
            end
        end
        if (last_col) begin
            acc_next = '0;
            col_next = '0;
            row_next = last_row ? '0 : RW'(row_reg + RW'(1));
        end else begin
            col_next = CW'(col_reg + CW'(1));
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            wf_reg   <= '0;
            ws_reg   <= '0;
            held_reg <= '0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            if (hold) begin
                wf_reg   <= es - right;
                ws_reg   <= right;
                held_reg <= s_pix;
            end
        end
    end

    assign q_push  = accept && (flags.blend || flags.exact);
    assign q_flags = flags;
    assign q_held  = held_reg;
    assign q_cur   = s_pix;
    assign q_wf    = wf_reg;
    assign q_ws    = ws_reg;

endmodule

// ===== design/hld_queue.sv =====
`timescale 1ns / 1ps

module hld_queue #(
    parameter int WGT_W = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hld_pkg::cmd_flags_t  in_flags,
    input  hld_pkg::pixel_t      in_held,
    input  hld_pkg::pixel_t      in_cur,
    input  logic [WGT_W-1:0]     in_wf,
    input  logic [WGT_W-1:0]     in_ws,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output hld_pkg::cmd_flags_t  out_flags,
    output hld_pkg::pixel_t      out_held,
    output hld_pkg::pixel_t      out_cur,
    output logic [WGT_W-1:0]     out_wf,
    output logic [WGT_W-1:0]     out_ws
);

    localparam int DEPTH = hld_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    hld_pkg::cmd_flags_t flags_mem [DEPTH];
    hld_pkg::pixel_t     held_mem  [DEPTH];
    hld_pkg::pixel_t     cur_mem   [DEPTH];
    logic [WGT_W-1:0]    wf_mem    [DEPTH];
    logic [WGT_W-1:0]    ws_mem    [DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full  = count_reg == NW'(DEPTH);
    assign empty = count_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : PW'(wr_ptr_reg + PW'(1));
            end
            if (pop) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : PW'(rd_ptr_reg + PW'(1));
            end
            if (push && !pop) begin
                count_reg <= NW'(count_reg + NW'(1));
            end else if (pop && !push) begin
                count_reg <= NW'(count_reg - NW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            flags_mem[wr_ptr_reg] <= in_flags;
            held_mem[wr_ptr_reg]  <= in_held;
            cur_mem[wr_ptr_reg]   <= in_cur;
            wf_mem[wr_ptr_reg]    <= in_wf;
            ws_mem[wr_ptr_reg]    <= in_ws;
        end
    end

    assign out_flags = flags_mem[rd_ptr_reg];
    assign out_held  = held_mem[rd_ptr_reg];
    assign out_cur   = cur_mem[rd_ptr_reg];
    assign out_wf    = wf_mem[rd_ptr_reg];
    assign out_ws    = ws_mem[rd_ptr_reg];

endmodule

// ===== design/hld_blend.sv =====
`timescale 1ns / 1ps

module hld_blend #(
    parameter int WGT_W = 13
) (
    input  logic                       aclk,
    input  hld_pkg::blend_ctl_t        ctl,
    input  logic [hld_pkg::PIX_W-1:0]  a,
    input  logic [hld_pkg::PIX_W-1:0]  b,
    input  logic [WGT_W-1:0]           wf,
    input  logic [WGT_W-1:0]           ws,
    output logic [hld_pkg::PIX_W-1:0]  quo
);

    localparam int PW = hld_pkg::PIX_W;
    localparam int NW = PW + WGT_W;

    logic [NW-1:0]    p1_reg, p2_reg;
    logic [WGT_W-1:0] den_reg, rem_reg;
    logic [PW-1:0]    dq_reg;
    logic [NW-1:0]    num;
    logic [WGT_W:0]   trial;
    logic             qbit;

    assign num   = p1_reg + p2_reg;
    assign trial = {rem_reg, dq_reg[PW-1]};
    assign qbit  = trial >= {1'b0, den_reg};

    // quotient is a weighted mean, so it fits in a pixel and the top bits
    // of the numerator start out below the divisor
    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            p1_reg  <= NW'(a) * NW'(wf);
            p2_reg  <= NW'(b) * NW'(ws);
            den_reg <= WGT_W'(wf + ws);
        end
        if (ctl.load) begin
            rem_reg <= num[NW-1:PW];
            dq_reg  <= num[PW-1:0];
        end else if (ctl.step) begin
            rem_reg <= qbit ? WGT_W'(trial - {1'b0, den_reg}) : trial[WGT_W-1:0];
            dq_reg  <= {dq_reg[PW-2:0], qbit};
        end
    end

    assign quo = dq_reg;

endmodule

// ===== design/hld_back.sv =====
`timescale 1ns / 1ps

module hld_back #(
    parameter int WGT_W = 13
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  hld_pkg::cmd_flags_t        q_flags,
    input  hld_pkg::pixel_t            q_held,
    input  hld_pkg::pixel_t            q_cur,
    input  logic [WGT_W-1:0]           q_wf,
    input  logic [WGT_W-1:0]           q_ws,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [hld_pkg::PIX_W-1:0]  m_y_out,
    output logic [hld_pkg::PIX_W-1:0]  m_u_out,
    output logic [hld_pkg::PIX_W-1:0]  m_v_out,
    output logic                       m_row_end,
    output logic                       m_frame_end,
    output logic                       m_last_of_run
);

    localparam int SW = $clog2(hld_pkg::PIX_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(hld_pkg::PIX_W - 1);

    hld_pkg::back_state_t state_reg, state_next;
    logic [SW-1:0]        step_reg;

    hld_pkg::cmd_flags_t flags_reg;
    hld_pkg::pixel_t     held_reg, cur_reg;
    logic [WGT_W-1:0]    wf_reg, ws_reg;

    hld_pkg::blend_ctl_t ctl;
    hld_pkg::pixel_t     mixed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hld_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            hld_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = q_flags.blend ? hld_pkg::BK_MUL : hld_pkg::BK_EXACT_OUT;
                end
            end
            hld_pkg::BK_MUL:  state_next = hld_pkg::BK_LOAD;
            hld_pkg::BK_LOAD: state_next = hld_pkg::BK_DIV;
            hld_pkg::BK_DIV: begin
                if (step_reg == STEP_LAST) begin
                    state_next = hld_pkg::BK_BLEND_OUT;
                end
            end
            hld_pkg::BK_BLEND_OUT: begin
                if (m_ready) begin
                    state_next = flags_reg.exact ? hld_pkg::BK_EXACT_OUT : hld_pkg::BK_IDLE;
                end
            end
            hld_pkg::BK_EXACT_OUT: begin
                if (m_ready) begin
                    state_next = hld_pkg::BK_IDLE;
                end
            end
            default: state_next = hld_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (state_reg == hld_pkg::BK_DIV) begin
            step_reg <= (step_reg == STEP_LAST) ? '0 : SW'(step_reg + SW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            flags_reg <= q_flags;
            held_reg  <= q_held;
            cur_reg   <= q_cur;
            wf_reg    <= q_wf;
            ws_reg    <= q_ws;
        end
    end

    assign ctl.mul  = state_reg == hld_pkg::BK_MUL;
    assign ctl.load = state_reg == hld_pkg::BK_LOAD;
    assign ctl.step = state_reg == hld_pkg::BK_DIV;

    hld_blend #(.WGT_W(WGT_W)) u_blend_y (
        .aclk (aclk), .ctl (ctl), .a (held_reg.y), .b (cur_reg.y),
        .wf (wf_reg), .ws (ws_reg), .quo (mixed.y)
    );

    hld_blend #(.WGT_W(WGT_W)) u_blend_u (
        .aclk (aclk), .ctl (ctl), .a (held_reg.u), .b (cur_reg.u),
        .wf (wf_reg), .ws (ws_reg), .quo (mixed.u)
    );

    hld_blend #(.WGT_W(WGT_W)) u_blend_v (
        .aclk (aclk), .ctl (ctl), .a (held_reg.v), .b (cur_reg.v),
        .wf (wf_reg), .ws (ws_reg), .quo (mixed.v)
    );

    // blend result goes out first, then the exact hit of the same pixel
    always_comb begin
        m_valid       = 1'b0;
        m_y_out       = cur_reg.y;
        m_u_out       = cur_reg.u;
        m_v_out       = cur_reg.v;
        m_row_end     = 1'b0;
        m_frame_end   = 1'b0;
        m_last_of_run = 1'b1;
        if (state_reg == hld_pkg::BK_BLEND_OUT) begin
            m_valid       = 1'b1;
            m_y_out       = mixed.y;
            m_u_out       = mixed.u;
            m_v_out       = mixed.v;
            m_last_of_run = !flags_reg.exact;
        end else if (state_reg == hld_pkg::BK_EXACT_OUT) begin
            m_valid     = 1'b1;
            m_row_end   = flags_reg.row_end;
            m_frame_end = flags_reg.frame_end;
        end
    end

endmodule

// ===== design/horizontal_linear_downscaler.sv =====
`timescale 1ns / 1ps

// horizontal linear downscaler for a yuv444 raster stream
// s_* channel: one source pixel per transaction, rows of src_width pixels,
//   frames of src_height rows; row and frame position are counted inside
// m_* channel: output pixels, row_end and frame_end on the last pixel of a
//   row and of a frame, last_of_run on the last output caused by one input
// cfg_*: write src_width (0), dst_width (1), src_height (2) while idle
// the front end tracks the phase and posts one command per producing pixel
//   into a two-entry queue; the back end executes commands one at a time
// an exact hit is written into the queue, popped and then offered; a blend
//   is offered once the pixel that completes it has passed pop, multiply,
//   load and 8 restoring divide steps of one quotient bit each
// flow: inputs that produce nothing are taken while the queue is not full;
//   the back end finishes each command, a blend and any exact hit behind it,
//   before popping the next; the queue lets input run ahead by two commands
// reset (aresetn low, synchronous): registers return to 640 x 480 at 1:1,
//   the queue empties and phase and counters clear
// a stalled m_ready holds the current result; input stops once the queue
//   is full
module horizontal_linear_downscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [hld_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hld_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [hld_pkg::PIX_W-1:0]  s_y_in,
    input  logic [hld_pkg::PIX_W-1:0]  s_u_in,
    input  logic [hld_pkg::PIX_W-1:0]  s_v_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [hld_pkg::PIX_W-1:0]  m_y_out,
    output logic [hld_pkg::PIX_W-1:0]  m_u_out,
    output logic [hld_pkg::PIX_W-1:0]  m_v_out,
    output logic                       m_row_end,
    output logic                       m_frame_end,
    output logic                       m_last_of_run
);

    localparam int WGT_W = $clog2(hld_pkg::eff_max(MAX_WIDTH) + 1);

    hld_pkg::pixel_t     s_pix;
    logic                push, full, empty, pop;
    hld_pkg::cmd_flags_t in_flags, out_flags;
    hld_pkg::pixel_t     in_held, in_cur, out_held, out_cur;
    logic [WGT_W-1:0]    in_wf, in_ws, out_wf, out_ws;

    assign s_pix.y = s_y_in;
    assign s_pix.u = s_u_in;
    assign s_pix.v = s_v_in;

    hld_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WGT_W      (WGT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pix     (s_pix),
        .q_full    (full),
        .q_push    (push),
        .q_flags   (in_flags),
        .q_held    (in_held),
        .q_cur     (in_cur),
        .q_wf      (in_wf),
        .q_ws      (in_ws)
    );

    hld_queue #(.WGT_W(WGT_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_flags  (in_flags),
        .in_held   (in_held),
        .in_cur    (in_cur),
        .in_wf     (in_wf),
        .in_ws     (in_ws),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_flags (out_flags),
        .out_held  (out_held),
        .out_cur   (out_cur),
        .out_wf    (out_wf),
        .out_ws    (out_ws)
    );

    hld_back #(.WGT_W(WGT_W)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (empty),
        .q_pop         (pop),
        .q_flags       (out_flags),
        .q_held        (out_held),
        .q_cur         (out_cur),
        .q_wf          (out_wf),
        .q_ws          (out_ws),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_y_out       (m_y_out),
        .m_u_out       (m_u_out),
        .m_v_out       (m_v_out),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end),
        .m_last_of_run (m_last_of_run)
    );

endmodule
